FILE: src/bilinear_rgba_downscaler_core_defines.svh
// Assertion macros for the bilinear RGBA downscaler
`ifndef BILINEAR_RGBA_DOWNSCALER_CORE_DEFINES_SVH
`define BILINEAR_RGBA_DOWNSCALER_CORE_DEFINES_SVH

// same-cycle implication
`define BRD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BRD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/brd_pkg.sv
// Shared types and constants of the bilinear RGBA downscaler
`default_nettype none
package brd_pkg;

  localparam int SIZE_W   = 13;
  localparam int NUM_W    = 26;
  localparam int DEN_W    = 14;
  localparam int ROW_W    = 12;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int MIX_CNT_W = 4;

  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_NUM,
    ST_DIV,
    ST_RD,
    ST_MIX,
    ST_OUT,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic take;
    logic mul;
    logic start;
    logic rd;
    logic mix;
    logic out_load;
    logic upd;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic emit;
    logic mix_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: src/brd_div.sv
// Restoring serial divider lane: one quotient bit per cycle
`default_nettype none
module brd_div
  import brd_pkg::*;
#(
  parameter int DIV_W    = 42,
  parameter int FRAC_POS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] numer,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [DIV_W-1:0]      quot,
  output logic                  frac_nz
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] dvd_r, dvd_nxt;
  logic [DIV_W-1:0] quot_r, quot_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic             fnz_r, fnz_nxt;
  logic [DEN_W:0]   trial;
  logic             ge;

  always_comb begin
    trial    = {rem_r, dvd_r[DIV_W-1]};
    ge       = trial >= {1'b0, den};
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    fnz_nxt  = fnz_r;
    if (start) begin
      cnt_nxt  = CNT_W'(DIV_W);
      dvd_nxt  = numer;
      quot_nxt = '0;
      rem_nxt  = '0;
      fnz_nxt  = 1'b0;
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
      dvd_nxt  = {dvd_r[DIV_W-2:0], 1'b0};
      quot_nxt = {quot_r[DIV_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(FRAC_POS + 1)) begin
        fnz_nxt = rem_nxt != '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    fnz_r  <= fnz_nxt;
  end

  assign done    = cnt_r == '0;
  assign quot    = quot_r;
  assign frac_nz = fnz_r;

endmodule
`default_nettype wire

FILE: src/brd_ctrl.sv
// Sequencing state machine of the downscaler
`default_nettype none
module brd_ctrl
  import brd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire sts_t sts,
  output logic      in_ready,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_NUM;
      ST_NUM:  state_nxt = ST_DIV;
      ST_DIV:  if (sts.div_done) state_nxt = sts.emit ? ST_RD : ST_UPD;
      ST_RD:   state_nxt = ST_MIX;
      ST_MIX:  if (sts.mix_done) state_nxt = ST_OUT;
      ST_OUT:  if (sts.out_free) state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_ready     = state_r == ST_IDLE;
    cmd.take     = (state_r == ST_IDLE) && in_valid;
    cmd.mul      = state_r == ST_MUL;
    cmd.start    = state_r == ST_NUM;
    cmd.rd       = state_r == ST_RD;
    cmd.mix      = state_r == ST_MIX;
    cmd.out_load = (state_r == ST_OUT) && sts.out_free;
    cmd.upd      = state_r == ST_UPD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/brd_dp.sv
// Datapath: registers, positions, row store, sample dividers and channel mixer
`default_nettype none
module brd_dp
  import brd_pkg::*;
#(
  parameter int MAX_WIDTH   = 4096,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic [31:0] in_pixel,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_scaled_pixel,
  output logic             out_frame_end,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata
);

  localparam int W      = WEIGHT_BITS;
  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int DIV_W  = NUM_W + W;
  localparam int TOP_W  = W + 8;
  localparam int ACC_W  = 2 * W + 8;
  localparam logic [W:0] ONE = (W+1)'(1) << W;

  // configuration
  logic [SIZE_W-1:0] src_w_r, src_h_r, dst_w_r, dst_h_r;
  reg_idx_t          widx;
  assign widx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= SIZE_W'(1);
      src_h_r <= SIZE_W'(1);
      dst_w_r <= SIZE_W'(1);
      dst_h_r <= SIZE_W'(1);
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_SRC_WIDTH:  src_w_r <= pwdata[SIZE_W-1:0];
        REG_SRC_HEIGHT: src_h_r <= pwdata[SIZE_W-1:0];
        REG_DST_WIDTH:  dst_w_r <= pwdata[SIZE_W-1:0];
        REG_DST_HEIGHT: dst_h_r <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_SRC_WIDTH:  prdata = 32'(src_w_r);
      REG_SRC_HEIGHT: prdata = 32'(src_h_r);
      REG_DST_WIDTH:  prdata = 32'(dst_w_r);
      REG_DST_HEIGHT: prdata = 32'(dst_h_r);
      default:        prdata = '0;
    endcase
  end

  // effective sizes
  logic [SIZE_W-1:0] sw, sh, dw, dh;
  always_comb begin
    if (src_w_r == '0) sw = SIZE_W'(1);
    else if (32'(src_w_r) > MAX_WIDTH) sw = SIZE_W'(MAX_WIDTH);
    else sw = src_w_r;
    if (src_h_r == '0) sh = SIZE_W'(1);
    else if (32'(src_h_r) > HEIGHT_LIMIT) sh = SIZE_W'(HEIGHT_LIMIT);
    else sh = src_h_r;
    if (dst_w_r == '0) dw = SIZE_W'(1);
    else if (dst_w_r > sw) dw = sw;
    else dw = dst_w_r;
    if (dst_h_r == '0) dh = SIZE_W'(1);
    else if (dst_h_r > sh) dh = sh;
    else dh = dst_h_r;
  end

  // stream position
  logic [SIZE_W-1:0] in_col_r, out_col_r, out_row_r;
  logic [ROW_W-1:0]  in_row_r;
  logic [31:0]       pix_r, prior_r;
  logic              row_valid, col_ok;
  logic [SIZE_W-1:0] dx, dy;

  assign row_valid = out_row_r < dh;
  assign col_ok    = out_col_r < dw;
  assign dx        = col_ok ? out_col_r : '0;
  assign dy        = row_valid ? out_row_r : '0;

  // sample numerators
  logic [NUM_W-1:0] prodx_r, limx_r, prody_r, limy_r;
  logic [NUM_W-1:0] nx, ny;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prodx_r <= NUM_W'({dx, 1'b1}) * NUM_W'(sw);
      limx_r  <= NUM_W'(sw - 1'b1) * NUM_W'({dw, 1'b0});
      prody_r <= NUM_W'({dy, 1'b1}) * NUM_W'(sh);
      limy_r  <= NUM_W'(sh - 1'b1) * NUM_W'({dh, 1'b0});
    end
  end

  always_comb begin
    nx = (prodx_r > NUM_W'(dw)) ? prodx_r - NUM_W'(dw) : '0;
    if (nx > limx_r) nx = limx_r;
    ny = (prody_r > NUM_W'(dh)) ? prody_r - NUM_W'(dh) : '0;
    if (ny > limy_r) ny = limy_r;
  end

  logic [DIV_W-1:0] qx, qy;
  logic             fx, fy, dxd, dyd;

  brd_div #(.DIV_W(DIV_W), .FRAC_POS(W)) u_div_x (
    .clk, .rst_n, .start(cmd.start), .numer({nx, {W{1'b0}}}), .den({dw, 1'b0}),
    .done(dxd), .quot(qx), .frac_nz(fx)
  );

  brd_div #(.DIV_W(DIV_W), .FRAC_POS(W)) u_div_y (
    .clk, .rst_n, .start(cmd.start), .numer({ny, {W{1'b0}}}), .den({dh, 1'b0}),
    .done(dyd), .quot(qy), .frac_nz(fy)
  );

  logic [SIZE_W-1:0] low_x, low_y, trig_x, trig_y;
  logic [SIZE_W:0]   tx, ty;
  logic [W-1:0]      wx, wy;
  logic              emit, row_hit;

  always_comb begin
    low_x = qx[W +: SIZE_W];
    low_y = qy[W +: SIZE_W];
    wx    = qx[W-1:0];
    wy    = qy[W-1:0];
    tx    = {1'b0, low_x} + (SIZE_W+1)'(fx);
    ty    = {1'b0, low_y} + (SIZE_W+1)'(fy);
    trig_x = (tx > {1'b0, sw - 1'b1}) ? sw - 1'b1 : tx[SIZE_W-1:0];
    trig_y = (ty > {1'b0, sh - 1'b1}) ? sh - 1'b1 : ty[SIZE_W-1:0];
    row_hit = row_valid && (SIZE_W'(in_row_r) == trig_y);
    emit    = row_hit && col_ok && (in_col_r == trig_x);
  end

  // row store
  logic [31:0]   mem [MAX_WIDTH];
  logic [31:0]   rd_a_r, rd_b_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = AW'(sw - 1'b1);
    if (cmd.mul && in_col_r == '0) begin
      mem_we = 1'b1;
    end else if (cmd.upd && in_col_r != '0 && 32'(in_col_r - 1'b1) < MAX_WIDTH) begin
      mem_we = 1'b1;
      mem_wa = AW'(in_col_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= prior_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_a_r <= mem[AW'(low_x)];
      rd_b_r <= mem[AW'(in_col_r)];
    end
  end

  // channel mixer
  logic [31:0]          tl, tr, bl, br, res_r;
  logic [MIX_CNT_W-1:0] mix_cnt_r;
  logic [1:0]           ch, ph;
  logic [7:0]           ca, cb, ce, cf;
  logic [TOP_W-1:0]     top_r, bot_r;
  logic [ACC_W-1:0]     acc_r, sum;
  logic [W:0]           wxc, wyc;

  always_comb begin
    bl  = fx ? prior_r : pix_r;
    br  = pix_r;
    tl  = fy ? rd_a_r : bl;
    tr  = fy ? (fx ? rd_b_r : rd_a_r) : br;
    ch  = mix_cnt_r[3:2];
    ph  = mix_cnt_r[1:0];
    ca  = tl[8*ch +: 8];
    cb  = tr[8*ch +: 8];
    ce  = bl[8*ch +: 8];
    cf  = br[8*ch +: 8];
    wxc = ONE - (W+1)'(wx);
    wyc = ONE - (W+1)'(wy);
    sum = acc_r + ACC_W'(bot_r) * ACC_W'(wy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_cnt_r <= '0;
    end else if (cmd.rd) begin
      mix_cnt_r <= '0;
    end else if (cmd.mix) begin
      mix_cnt_r <= mix_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mix) begin
      unique case (ph)
        2'd0: top_r <= TOP_W'(ca) * TOP_W'(wxc) + TOP_W'(cb) * TOP_W'(wx);
        2'd1: bot_r <= TOP_W'(ce) * TOP_W'(wxc) + TOP_W'(cf) * TOP_W'(wx);
        2'd2: acc_r <= ACC_W'(top_r) * ACC_W'(wyc);
        2'd3: res_r[8*ch +: 8] <= sum[2*W +: 8];
        default: ;
      endcase
    end
  end

  // output register
  logic out_valid_r, out_fe_r;
  logic [31:0] out_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pix_r <= res_r;
      out_fe_r  <= (out_row_r == dh - 1'b1) && (out_col_r == dw - 1'b1);
    end
  end

  // position update
  logic              col_end;
  logic [SIZE_W-1:0] in_col_nxt, out_col_nxt, out_row_nxt;
  logic [ROW_W-1:0]  in_row_nxt;

  always_comb begin
    col_end     = ({1'b0, in_col_r} + 1'b1) >= {1'b0, sw};
    in_col_nxt  = in_col_r + 1'b1;
    in_row_nxt  = in_row_r;
    out_col_nxt = emit ? out_col_r + 1'b1 : out_col_r;
    out_row_nxt = out_row_r;
    if (col_end) begin
      in_col_nxt = '0;
      if (row_hit) begin
        out_row_nxt = out_row_r + 1'b1;
        out_col_nxt = '0;
      end
      if (({1'b0, SIZE_W'(in_row_r)} + 1'b1) >= {1'b0, sh}) begin
        in_row_nxt  = '0;
        out_row_nxt = '0;
        out_col_nxt = '0;
      end else begin
        in_row_nxt = in_row_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      prior_r   <= '0;
    end else if (cmd.upd) begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      prior_r   <= pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pix_r <= in_pixel;
    end
  end

  assign sts.div_done = dxd && dyd;
  assign sts.emit     = emit;
  assign sts.mix_done = mix_cnt_r == '1;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_scaled_pixel = out_pix_r;
  assign out_frame_end    = out_fe_r;

endmodule
`default_nettype wire

FILE: src/bilinear_rgba_downscaler_core.sv
// Top level of the bilinear RGBA downscaler
`default_nettype none
`include "bilinear_rgba_downscaler_core_defines.svh"
// Takes source RGBA pixels in raster order and emits bilinear, half-pixel-centered
// downscaled pixels. One pixel is processed at a time: each pixel passes through
// the two serial sample dividers, which produce 26 + WEIGHT_BITS quotient bits one
// per cycle, and a pixel that completes an output also passes through the mixer,
// which runs four multiply steps per color channel, and waits for out_ready if the
// result register is still full. The result register lets a finished pixel wait
// while the next source pixel is taken. Sizes are written over the APB port while
// idle; the user is bound to this, the block itself does not enforce it.
module bilinear_rgba_downscaler_core
  import brd_pkg::*;
#(
  parameter int MAX_WIDTH   = 4096,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_pixel,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_scaled_pixel,
  output logic             out_frame_end,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  brd_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .sts, .in_ready, .cmd
  );

  brd_dp #(.MAX_WIDTH(MAX_WIDTH), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_pixel, .out_valid, .out_ready,
    .out_scaled_pixel, .out_frame_end, .psel, .penable, .pwrite, .paddr,
    .pwdata, .prdata
  );

  `BRD_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready, "second beat taken while busy")
  `BRD_ASSERT_NOW(a_load_emit, cmd.out_load, sts.emit, "result loaded for a non-emitting pixel")
  `BRD_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_valid || out_ready, "result overwritten")

endmodule
`default_nettype wire
